// ===== hw/rtl/crast_pkg.sv =====
// Shared types, widths and codes for the circle outline rasterizer.
package crast_pkg;

  localparam int COORD_BITS  = 16;
  localparam int RADIUS_BITS = 12;

  // Offsets hold 0..radius plus the final step to -1.
  localparam int OFS_W = RADIUS_BITS + 1;
  // Decision term stays within a few times the radius.
  localparam int DEC_W = RADIUS_BITS + 3;
  localparam int SUM_W = (COORD_BITS > OFS_W) ? COORD_BITS : OFS_W;

  localparam int GROUP_PTS = 8;
  localparam int PHASE_W   = $clog2(GROUP_PTS);

  localparam int GRP_DEPTH = 2;
  localparam int GRP_PTR_W = $clog2(GRP_DEPTH);
  localparam int GRP_CNT_W = $clog2(GRP_DEPTH + 1);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // One iteration's worth of work for the point emitter.
  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic signed [OFS_W-1:0] ofs_a;
    logic signed [OFS_W-1:0] ofs_b;
    logic done;
  } grp_t;

endpackage

// ===== hw/rtl/crast_front.sv =====
// Front end: takes transactions, runs the decision update, queues point groups.
module crast_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  logic                                   operation,
  input  logic signed [crast_pkg::COORD_BITS-1:0] center_x,
  input  logic signed [crast_pkg::COORD_BITS-1:0] center_y,
  input  logic [crast_pkg::RADIUS_BITS-1:0]       radius,
  output logic                                   grp_push,
  output crast_pkg::grp_t                        grp_data
);

  logic                                   active_r, active_nxt;
  logic signed [crast_pkg::OFS_W-1:0]     a_r, a_nxt;
  logic signed [crast_pkg::OFS_W-1:0]     b_r, b_nxt;
  logic signed [crast_pkg::DEC_W-1:0]     d_r, d_nxt;
  logic [crast_pkg::COORD_BITS-1:0]       cx_r, cx_nxt;
  logic [crast_pkg::COORD_BITS-1:0]       cy_r, cy_nxt;
  logic [crast_pkg::RADIUS_BITS-1:0]      r_r, r_nxt;

  logic signed [crast_pkg::DEC_W-1:0]     a_w, b_w, r_w, two_a;
  logic signed [crast_pkg::OFS_W-1:0]     a_upd, b_upd;
  logic signed [crast_pkg::DEC_W-1:0]     d_upd;
  logic                                   done_upd;
  logic                                   is_adv;

  always_comb begin
    a_w   = crast_pkg::DEC_W'(a_r);
    b_w   = crast_pkg::DEC_W'(b_r);
    r_w   = crast_pkg::DEC_W'(r_r);
    two_a = a_w + a_w;
    a_upd = a_r;
    b_upd = b_r;
    if (d_r >= two_a) begin
      d_upd = d_r - two_a - crast_pkg::DEC_W'(1);
      a_upd = a_r + crast_pkg::OFS_W'(1);
    end else if (d_r < ((r_w - b_w) + (r_w - b_w))) begin
      d_upd = d_r + b_w + b_w - crast_pkg::DEC_W'(1);
      b_upd = b_r - crast_pkg::OFS_W'(1);
    end else begin
      d_upd = d_r + ((b_w - a_w - crast_pkg::DEC_W'(1)) + (b_w - a_w - crast_pkg::DEC_W'(1)));
      a_upd = a_r + crast_pkg::OFS_W'(1);
      b_upd = b_r - crast_pkg::OFS_W'(1);
    end
    done_upd = (b_upd < a_upd);
  end

  always_comb begin
    is_adv     = (operation == crast_pkg::OP_ADVANCE);
    active_nxt = active_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    d_nxt      = d_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    r_nxt      = r_r;
    grp_push   = 1'b0;
    if (accept) begin
      if (!is_adv) begin
        cx_nxt     = center_x;
        cy_nxt     = center_y;
        r_nxt      = radius;
        a_nxt      = '0;
        b_nxt      = crast_pkg::OFS_W'(radius);
        d_nxt      = crast_pkg::DEC_W'(radius) - crast_pkg::DEC_W'(1);
        active_nxt = 1'b1;
      end else if (active_r) begin
        grp_push = 1'b1;
        a_nxt    = a_upd;
        b_nxt    = b_upd;
        d_nxt    = d_upd;
        if (done_upd) begin
          active_nxt = 1'b0;
        end
      end
    end
    grp_data.cx    = cx_r;
    grp_data.cy    = cy_r;
    grp_data.ofs_a = a_r;
    grp_data.ofs_b = b_r;
    grp_data.done  = done_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      a_r      <= '0;
      b_r      <= '0;
      d_r      <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      r_r      <= '0;
    end else begin
      active_r <= active_nxt;
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      d_r      <= d_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      r_r      <= r_nxt;
    end
  end

endmodule

// ===== hw/rtl/crast_fifo.sv =====
// Short group queue between the front end and the point emitter.
module crast_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  crast_pkg::grp_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output crast_pkg::grp_t pop_data
);

  crast_pkg::grp_t                    mem_r [crast_pkg::GRP_DEPTH];
  logic [crast_pkg::GRP_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [crast_pkg::GRP_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [crast_pkg::GRP_CNT_W-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    full     = (cnt_r == crast_pkg::GRP_CNT_W'(crast_pkg::GRP_DEPTH));
    valid    = (cnt_r != '0);
    pop_data = mem_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == crast_pkg::GRP_PTR_W'(crast_pkg::GRP_DEPTH - 1)) ?
                   '0 : wr_ptr_r + crast_pkg::GRP_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == crast_pkg::GRP_PTR_W'(crast_pkg::GRP_DEPTH - 1)) ?
                   '0 : rd_ptr_r + crast_pkg::GRP_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + crast_pkg::GRP_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - crast_pkg::GRP_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("group queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !valid |-> !pop)
    else $error("group queue read while empty");
`endif

endmodule

// ===== hw/rtl/crast_back.sv =====
// Back end: walks the eight mirrored points of a group into the output register.
module crast_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   grp_valid,
  input  crast_pkg::grp_t                        grp_data,
  output logic                                   grp_take,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [crast_pkg::COORD_BITS-1:0] out_point_x,
  output logic signed [crast_pkg::COORD_BITS-1:0] out_point_y,
  output logic                                   out_last_of_group,
  output logic                                   out_circle_done
);

  crast_pkg::grp_t                   desc_r, desc_nxt;
  logic                              busy_r, busy_nxt;
  logic [crast_pkg::PHASE_W-1:0]     phase_r, phase_nxt;
  logic                              ovalid_r, ovalid_nxt;
  logic [crast_pkg::COORD_BITS-1:0]  px_r, px_nxt;
  logic [crast_pkg::COORD_BITS-1:0]  py_r, py_nxt;
  logic                              last_r, last_nxt;
  logic                              done_r, done_nxt;

  logic                              load_out, adv, at_end;
  logic signed [crast_pkg::OFS_W-1:0] ox, oy;
  logic signed [crast_pkg::SUM_W-1:0] ox_w, oy_w;

  // phase bit 0 swaps a/b, bit 1 negates x, bit 2 negates y
  always_comb begin
    ox = phase_r[0] ? desc_r.ofs_b : desc_r.ofs_a;
    oy = phase_r[0] ? desc_r.ofs_a : desc_r.ofs_b;
    if (phase_r[1]) begin
      ox = -ox;
    end
    if (phase_r[2]) begin
      oy = -oy;
    end
    ox_w = crast_pkg::SUM_W'(ox);
    oy_w = crast_pkg::SUM_W'(oy);
  end

  always_comb begin
    load_out = !ovalid_r || out_pop;
    adv      = busy_r && load_out;
    at_end   = (phase_r == crast_pkg::PHASE_W'(crast_pkg::GROUP_PTS - 1));
    grp_take = grp_valid && (!busy_r || (adv && at_end));

    desc_nxt   = desc_r;
    busy_nxt   = busy_r;
    phase_nxt  = phase_r;
    ovalid_nxt = ovalid_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    last_nxt   = last_r;
    done_nxt   = done_r;

    if (adv) begin
      ovalid_nxt = 1'b1;
      px_nxt     = desc_r.cx + ox_w[crast_pkg::COORD_BITS-1:0];
      py_nxt     = desc_r.cy + oy_w[crast_pkg::COORD_BITS-1:0];
      last_nxt   = at_end;
      done_nxt   = at_end && desc_r.done;
      phase_nxt  = phase_r + crast_pkg::PHASE_W'(1);
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end else if (out_pop) begin
      ovalid_nxt = 1'b0;
    end

    if (grp_take) begin
      desc_nxt  = grp_data;
      busy_nxt  = 1'b1;
      phase_nxt = '0;
    end

    out_empty         = !ovalid_r;
    out_point_x       = px_r;
    out_point_y       = py_r;
    out_last_of_group = last_r;
    out_circle_done   = done_r;
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      phase_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && done_r) |-> last_r)
    else $error("done flag on a point that is not last of its group");

  a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !adv && !grp_take) |=> $stable(phase_r))
    else $error("point phase moved while output stalled");

  a_take_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    grp_take |-> (!busy_r || at_end))
    else $error("new group taken before current group finished");
`endif

endmodule

// ===== hw/rtl/circle_outline_rasterizer.sv =====
// Top level of the circle outline rasterizer: front end, group queue, point emitter.
//
// Input channel (in_push / in_full): a transaction is taken when in_push is high and
// in_full is low. in_operation selects start (load center and radius, no output)
// or advance (emit the eight mirrored points of the current offsets, then step).
// An advance with no circle in progress produces nothing.
// Result channel (out_empty / out_pop): the oldest point sits on out_point_x/y
// while out_empty is low and leaves on a clock edge with out_pop high.
// out_last_of_group marks the eighth point of an iteration; out_circle_done
// is set on that point once the outline is complete.
// The first point of an advance passes through the group queue, the emitter's
// group register and its output register. Throughput: one point per cycle while
// the receiver pops every point, set by the single output register of the point
// emitter. A two-entry group queue lets the front end run ahead of it.
// When the receiver stalls, points hold and the queue fills; in_full then rises.
// Reset (rst_n low, synchronous) drops any circle and all queued points.
module circle_outline_rasterizer (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic                                   in_operation,
  input  logic signed [crast_pkg::COORD_BITS-1:0] in_center_x,
  input  logic signed [crast_pkg::COORD_BITS-1:0] in_center_y,
  input  logic [crast_pkg::RADIUS_BITS-1:0]       in_radius,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [crast_pkg::COORD_BITS-1:0] out_point_x,
  output logic signed [crast_pkg::COORD_BITS-1:0] out_point_y,
  output logic                                   out_last_of_group,
  output logic                                   out_circle_done
);

  logic            accept;
  logic            grp_push;
  crast_pkg::grp_t grp_wdata;
  logic            grp_valid;
  logic            grp_take;
  crast_pkg::grp_t grp_rdata;

  assign accept = in_push && !in_full;

  crast_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_operation),
    .center_x  (in_center_x),
    .center_y  (in_center_y),
    .radius    (in_radius),
    .grp_push  (grp_push),
    .grp_data  (grp_wdata)
  );

  crast_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (grp_push),
    .push_data (grp_wdata),
    .full      (in_full),
    .pop       (grp_take),
    .valid     (grp_valid),
    .pop_data  (grp_rdata)
  );

  crast_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .grp_valid         (grp_valid),
    .grp_data          (grp_rdata),
    .grp_take          (grp_take),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_last_of_group (out_last_of_group),
    .out_circle_done   (out_circle_done)
  );

endmodule
